// ===== sv/psc_pkg.sv =====
// Shared constants for the prime sieve chain.
`timescale 1ns / 1ps

package psc_pkg;

    // Candidate field width fixed by the stream format, and the smallest prime
    localparam int CAND_BITS = 16;
    localparam int MIN_PRIME = 2;

endpackage

// ===== sv/psc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps

module psc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/prime_sieve_chain_core.sv =====
// Prime sieve chain: stored primes in a RAM, candidates tested by a serial remainder unit.
`timescale 1ns / 1ps

//  channel  | dir | tdata                 | tuser      | tlast
//  s_axis   | in  | [15:0] candidate      | -          | end_of_list
//  m_axis   | out | [15:0] prime_value    | [0] overflow | -
//
//  One word at a time. Each word is tested against the stored primes in turn
//  (all of them for a prime, up to the first divisor otherwise), each by a RAM read state
//  and then one remainder bit a cycle over W = min(VALUE_BITS, 16) bits.
//  Reset clears the stage count and the controller; the prime RAM is not cleared.
//  A result waits in the output register; a new candidate is taken meanwhile,
//  but that word, with or without a result, holds in its last cycle until the register empties.

module prime_sieve_chain_core #(
    parameter int STAGES     = 32,
    parameter int VALUE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] candidate
    input  logic        s_axis_tlast,   // end_of_list
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] prime_value
    output logic [0:0]  m_axis_tuser    // [0] overflow
);

    localparam int W  = (VALUE_BITS < psc_pkg::CAND_BITS) ? VALUE_BITS : psc_pkg::CAND_BITS;
    localparam int IW = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int UW = $clog2(STAGES + 1);
    localparam int BW = $clog2(W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [W-1:0]  cand_reg, cand_next;
    logic          last_reg, last_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [UW-1:0] used_reg, used_next;
    logic [W-1:0]  div_reg, div_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic          hit_reg, hit_next;     // candidate found prime
    logic          ovf_reg, ovf_next;
    logic          ovalid_reg, ovalid_next;
    logic [15:0]   odata_reg, odata_next;
    logic          ouser_reg, ouser_next;

    logic [W-1:0]  ram_rdata;
    logic          ram_we;
    logic [W-1:0]  cand_in;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic [W-1:0]  rem_step;
    logic          store_full;
    logic          slot_free;
    logic [15:0]   cand_ext;

    psc_ram #(
        .WIDTH (W),
        .DEPTH (STAGES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (used_reg[IW-1:0]),
        .wdata (cand_reg),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    assign cand_in    = s_axis_tdata[W-1:0];
    assign store_full = (used_reg == UW'(STAGES));
    assign slot_free  = !ovalid_reg || m_axis_tready;

    // restoring remainder step, MSB of candidate first
    assign shifted  = {rem_reg, cand_reg[W - 1 - int'(bit_reg)]};
    assign diff     = shifted - {1'b0, div_reg};
    assign rem_step = diff[W] ? shifted[W-1:0] : diff[W-1:0];

    always_comb
    begin
        cand_ext        = '0;
        cand_ext[W-1:0] = cand_reg;
    end

    assign ram_we = (state_reg == ST_FIN) && slot_free && hit_reg && !ovf_reg;

    always_comb
    begin
        state_next  = state_reg;
        cand_next   = cand_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        used_next   = used_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        bit_next    = bit_reg;
        hit_next    = hit_reg;
        ovf_next    = ovf_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;

        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cand_next = cand_in;
                    last_next = s_axis_tlast;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    ovf_next  = store_full;
                    if (cand_in < W'(psc_pkg::MIN_PRIME))
                    begin
                        state_next = ST_FIN;
                    end
                    else if (used_reg == '0)
                    begin
                        hit_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                div_next   = ram_rdata;
                rem_next   = '0;
                bit_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                bit_next = bit_reg + 1'b1;
                if (bit_reg == BW'(W - 1))
                begin
                    if (rem_step == '0)
                    begin
                        state_next = ST_FIN;         // divisible: no word
                    end
                    else if (UW'(idx_reg) + 1'b1 == used_reg)
                    begin
                        hit_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    if (hit_reg)
                    begin
                        ovalid_next = 1'b1;
                        odata_next  = cand_ext;
                        ouser_next  = ovf_reg;
                        if (!ovf_reg)
                        begin
                            used_next = used_reg + 1'b1;
                        end
                    end
                    if (last_reg)
                    begin
                        used_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            used_reg   <= '0;
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            ovalid_reg <= ovalid_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg  <= cand_next;
        last_reg  <= last_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        hit_reg   <= hit_next;
        ovf_reg   <= ovf_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;

endmodule

// ===== sv/psc_checker.sv =====
// Port-level checks for the prime sieve chain, bound to the top level.
`timescale 1ns / 1ps

module psc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // held word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    a_prime_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata >= 16'(psc_pkg::MIN_PRIME))
        else $error("reported prime below two");

    // one candidate in flight: busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while testing");

    // a new result is only loaded at the end of a test, never while idle
    a_result_from_test: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a finished test");

endmodule

bind prime_sieve_chain_core psc_checker u_psc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
